/* design/trp_pkg.sv */
`timescale 1ns / 1ps

package trp_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_PERIOD    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_TOP_WIDTH = 3'd2;
    localparam logic [2:0] CFG_RAMP      = 3'd3;
    localparam logic [2:0] CFG_OFFSET    = 3'd4;

    // Magnitude of the offset difference, and stages of the modulo pipeline.
    localparam int unsigned MOD_BITS = 33;
    // Quotient bits, and stages of the ramp divider pipeline.
    localparam int unsigned DIV_BITS = 32;
    // Width of the doubled-unit region bounds, signed.
    localparam int unsigned BND_BITS = 36;

    typedef enum logic [1:0] {
        REG_TOP,
        REG_RAMP,
        REG_ZERO
    } region_t;

    typedef struct packed {
        logic [30:0]                 period;
        logic signed [31:0]          height;
        logic [31:0]                 h_mag;
        logic                        h_neg;
        logic [31:0]                 two_e;
        logic                        e_zero;
        logic signed [BND_BITS-1:0]  b_top;
        logic signed [BND_BITS-1:0]  b_rise;
        logic signed [BND_BITS-1:0]  b_gap;
        logic signed [BND_BITS-1:0]  b_fall;
    } cfg_t;

endpackage

/* design/trp_cfg.sv */
`timescale 1ns / 1ps

module trp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [31:0]         wr_data,
    output trp_pkg::cfg_t       cfg
);

    logic [30:0]        period_reg;
    logic signed [31:0] height_reg;
    logic [30:0]        top_width_reg;
    logic [30:0]        ramp_reg;

    logic signed [trp_pkg::BND_BITS-1:0] b_top_reg;
    logic signed [trp_pkg::BND_BITS-1:0] b_rise_reg;
    logic signed [trp_pkg::BND_BITS-1:0] b_gap_reg;
    logic signed [trp_pkg::BND_BITS-1:0] b_fall_reg;
    logic signed [trp_pkg::BND_BITS-1:0] b_top_next;
    logic signed [trp_pkg::BND_BITS-1:0] b_rise_next;
    logic signed [trp_pkg::BND_BITS-1:0] b_gap_next;
    logic signed [trp_pkg::BND_BITS-1:0] b_fall_next;
    logic signed [trp_pkg::BND_BITS-1:0] two_p_wide;
    logic signed [trp_pkg::BND_BITS-1:0] two_e_wide;
    logic [31:0]        h_mag_reg;
    logic [31:0]        h_mag_next;
    logic               h_neg_reg;
    logic [31:0]        two_e_reg;
    logic               e_zero_reg;

    // The center offset is held at the top level, next to its only user.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 31'd65536;
            height_reg    <= 32'sd65536;
            top_width_reg <= 31'd32768;
            ramp_reg      <= 31'd0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                trp_pkg::CFG_PERIOD:    period_reg    <= wr_data[30:0];
                trp_pkg::CFG_HEIGHT:    height_reg    <= wr_data;
                trp_pkg::CFG_TOP_WIDTH: top_width_reg <= wr_data[30:0];
                trp_pkg::CFG_RAMP:      ramp_reg      <= wr_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    // All region bounds are kept in doubled units so an odd top width is exact.
    always_comb
    begin
        two_p_wide  = $signed({4'b0000, period_reg, 1'b0});
        two_e_wide  = $signed({4'b0000, ramp_reg, 1'b0});
        b_top_next  = $signed({5'b00000, top_width_reg});
        b_rise_next = b_top_next + two_e_wide;
        b_fall_next = two_p_wide - b_top_next;
        b_gap_next  = b_fall_next - two_e_wide;
        h_mag_next  = height_reg[31] ? 32'(-height_reg) : height_reg;
    end

    // The derived values follow the registers in the next cycle; an item does
    // not reach the stages that use them until long after that.
    always_ff @(posedge clk)
    begin
        b_top_reg  <= b_top_next;
        b_rise_reg <= b_rise_next;
        b_gap_reg  <= b_gap_next;
        b_fall_reg <= b_fall_next;
        h_mag_reg  <= h_mag_next;
        h_neg_reg  <= height_reg[31];
        two_e_reg  <= {ramp_reg, 1'b0};
        e_zero_reg <= (ramp_reg == 31'd0);
    end

    always_comb
    begin
        cfg.period = period_reg;
        cfg.height = height_reg;
        cfg.h_mag  = h_mag_reg;
        cfg.h_neg  = h_neg_reg;
        cfg.two_e  = two_e_reg;
        cfg.e_zero = e_zero_reg;
        cfg.b_top  = b_top_reg;
        cfg.b_rise = b_rise_reg;
        cfg.b_gap  = b_gap_reg;
        cfg.b_fall = b_fall_reg;
    end

endmodule

/* design/trp_mod.sv */
`timescale 1ns / 1ps

module trp_mod (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_v,
    input  logic signed [31:0]                  position,
    input  logic signed [31:0]                  offset,
    input  trp_pkg::cfg_t                       cfg,
    output logic                                m_v,
    output logic [trp_pkg::MOD_BITS-1:0]        m
);

    localparam int unsigned NB = trp_pkg::MOD_BITS;

    logic signed [NB-1:0] diff;
    logic [NB-1:0]        abs_next;
    logic [NB-1:0]        abs_reg;
    logic                 abs_v_reg;

    logic [30:0]          rem_reg  [NB];
    logic [NB-1:0]        dabs_reg [NB];
    logic                 v_reg    [NB];

    // The difference is formed exactly at 33 bits, then folded to a magnitude.
    always_comb
    begin
        diff     = $signed({position[31], position}) - $signed({offset[31], offset});
        abs_next = diff[NB-1] ? NB'(-diff) : NB'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_v_reg <= 1'b0;
        end
        else if (en)
        begin
            abs_v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_reg <= abs_next;
        end
    end

    // Restoring remainder, one dividend bit per stage, most significant first.
    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        logic [30:0]   rem_prev;
        logic [NB-1:0] dabs_prev;
        logic          v_prev;
        logic [31:0]   trial;
        logic          fits;
        logic [30:0]   rem_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign dabs_prev = abs_reg;
            assign v_prev    = abs_v_reg;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign dabs_prev = dabs_reg[k-1];
            assign v_prev    = v_reg[k-1];
        end

        assign trial    = {rem_prev, dabs_prev[NB-1-k]};
        assign fits     = (trial >= {1'b0, cfg.period});
        assign rem_next = fits ? 31'(trial - {1'b0, cfg.period}) : trial[30:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dabs_reg[k] <= dabs_prev;
            end
        end
    end

    // A zero period skips the reduction and passes the magnitude through.
    assign m_v = v_reg[NB-1];
    assign m   = (cfg.period == 31'd0) ? dabs_reg[NB-1] : {2'b00, rem_reg[NB-1]};

endmodule

/* design/trp_region.sv */
`timescale 1ns / 1ps

module trp_region (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                m_v,
    input  logic [trp_pkg::MOD_BITS-1:0]        m,
    input  trp_pkg::cfg_t                       cfg,
    output logic                                prod_v,
    output logic [63:0]                         prod,
    output trp_pkg::region_t                    region
);

    localparam int unsigned BW = trp_pkg::BND_BITS;

    logic signed [BW-1:0] m2_next;
    logic [3:0]           le_next;
    logic signed [BW-1:0] m2_reg;
    logic [3:0]           le_reg;
    logic                 cmp_v_reg;

    logic signed [BW-1:0] rise_diff;
    logic signed [BW-1:0] fall_diff;
    logic [31:0]          dist_next;
    trp_pkg::region_t     dist_rg_next;
    logic [31:0]          dist_reg;
    trp_pkg::region_t     dist_rg_reg;
    logic                 dist_v_reg;

    logic [63:0]          prod_reg;
    trp_pkg::region_t     prod_rg_reg;
    logic                 prod_v_reg;

    always_comb
    begin
        m2_next    = $signed({2'b00, m, 1'b0});
        le_next[0] = (m2_next <= cfg.b_top);
        le_next[1] = (m2_next <= cfg.b_rise);
        le_next[2] = (m2_next <= cfg.b_gap);
        le_next[3] = (m2_next <= cfg.b_fall);
    end

    // The first bound that holds picks the region, which also settles an
    // overlapping (invalid) configuration.
    always_comb
    begin
        rise_diff    = cfg.b_rise - m2_reg;
        fall_diff    = m2_reg - cfg.b_gap;
        dist_next    = 32'd0;
        dist_rg_next = trp_pkg::REG_TOP;
        priority if (le_reg[0])
        begin
            dist_rg_next = trp_pkg::REG_TOP;
        end
        else if (le_reg[1])
        begin
            dist_rg_next = trp_pkg::REG_RAMP;
            dist_next    = rise_diff[31:0];
        end
        else if (le_reg[2])
        begin
            dist_rg_next = trp_pkg::REG_ZERO;
        end
        else if (le_reg[3])
        begin
            dist_rg_next = trp_pkg::REG_RAMP;
            dist_next    = fall_diff[31:0];
        end
        else
        begin
            dist_rg_next = trp_pkg::REG_TOP;
        end
        // With no ramp length both ramps are empty and read as zero.
        if (cfg.e_zero && dist_rg_next == trp_pkg::REG_RAMP)
        begin
            dist_rg_next = trp_pkg::REG_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg  <= 1'b0;
            dist_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else if (en)
        begin
            cmp_v_reg  <= m_v;
            dist_v_reg <= cmp_v_reg;
            prod_v_reg <= dist_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg      <= m2_next;
            le_reg      <= le_next;
            dist_reg    <= dist_next;
            dist_rg_reg <= dist_rg_next;
            prod_reg    <= cfg.h_mag * dist_reg;
            prod_rg_reg <= dist_rg_reg;
        end
    end

    assign prod_v = prod_v_reg;
    assign prod   = prod_reg;
    assign region = prod_rg_reg;

`ifndef SYNTHESIS
    a_top_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmp_v_reg && le_reg[0]) |=> (dist_rg_reg == trp_pkg::REG_TOP))
        else $error("position inside the flat top was not classed as top");

    a_rise_class: assert property (@(posedge clk) disable iff (!rst_n)
        (en && cmp_v_reg && !le_reg[0] && le_reg[1])
        |=> (dist_rg_reg == trp_pkg::REG_RAMP || dist_rg_reg == trp_pkg::REG_ZERO))
        else $error("position on the rising ramp was classed as top");
`endif

endmodule

/* design/trp_div.sv */
`timescale 1ns / 1ps

module trp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                prod_v,
    input  logic [63:0]                         prod,
    input  trp_pkg::region_t                    region_in,
    input  trp_pkg::cfg_t                       cfg,
    output logic                                q_v,
    output logic [trp_pkg::DIV_BITS-1:0]        quotient,
    output trp_pkg::region_t                    region_out
);

    localparam int unsigned NQ = trp_pkg::DIV_BITS;

    logic [NQ-1:0]    rem_reg [NQ];
    logic [NQ-1:0]    lo_reg  [NQ];
    trp_pkg::region_t rg_reg  [NQ];
    logic             v_reg   [NQ];

    // The product never reaches divisor * 2^32 in a ramp, so its upper half
    // seeds the remainder and 32 steps give the whole quotient.
    for (genvar k = 0; k < NQ; k++)
    begin : g_stage
        logic [NQ-1:0]    rem_prev;
        logic [NQ-1:0]    lo_prev;
        trp_pkg::region_t rg_prev;
        logic             v_prev;
        logic [NQ:0]      trial;
        logic             fits;
        logic [NQ-1:0]    rem_next;
        logic [NQ-1:0]    lo_next;

        if (k == 0)
        begin : g_first
            assign rem_prev = prod[2*NQ-1:NQ];
            assign lo_prev  = prod[NQ-1:0];
            assign rg_prev  = region_in;
            assign v_prev   = prod_v;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign lo_prev  = lo_reg[k-1];
            assign rg_prev  = rg_reg[k-1];
            assign v_prev   = v_reg[k-1];
        end

        assign trial    = {rem_prev, lo_prev[NQ-1]};
        assign fits     = (trial >= {1'b0, cfg.two_e});
        assign rem_next = fits ? NQ'(trial - {1'b0, cfg.two_e}) : trial[NQ-1:0];
        assign lo_next  = {lo_prev[NQ-2:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                lo_reg[k]  <= lo_next;
                rg_reg[k]  <= rg_prev;
            end
        end
    end

    assign q_v        = v_reg[NQ-1];
    assign quotient   = lo_reg[NQ-1];
    assign region_out = rg_reg[NQ-1];

endmodule

/* design/trapezoid_pulse_sample.sv */
// Periodic trapezoidal pulse sampler, all values signed Q16.16.
// Input channel: position with in_valid / in_stall; one request is taken at
// each rising edge with in_valid high and in_stall low. Output channel: level
// with out_valid / out_stall, one result per input request, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 period, 1 height,
// 2 top width, 3 ramp length, 4 center offset) and cfg_data; cfg_ready is
// always high. Write registers only while no request is in flight.
// The pipe has 70 register stages: one stage forms the offset magnitude, 33
// stages reduce it modulo the period a bit at a time, three stages classify
// the region, form the ramp distance and multiply by the height, 32 stages
// divide by twice the ramp length, and one is the output register.
// Throughput is one request per cycle while the pipe is not held by out_stall.
// Reset clears every valid bit in the pipe and loads the registers with
// period 1.0, height 1.0, top width 0.5, no ramp and zero offset.
// While out_valid is high and out_stall is high the whole pipe holds, so
// in_stall rises in the same cycle; nothing is dropped or duplicated.
`timescale 1ns / 1ps

module trapezoid_pulse_sample (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  level,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    trp_pkg::cfg_t                  cfg;
    logic signed [31:0]             offset_reg;
    logic                           en;
    logic                           m_v;
    logic [trp_pkg::MOD_BITS-1:0]   m;
    logic                           prod_v;
    logic [63:0]                    prod;
    trp_pkg::region_t               prod_rg;
    logic                           q_v;
    logic [trp_pkg::DIV_BITS-1:0]   quotient;
    trp_pkg::region_t               q_rg;
    logic signed [31:0]             level_next;
    logic signed [31:0]             level_reg;
    logic                           out_valid_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;

    // The offset is held here, next to the first stage that uses it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 32'sd0;
        end
        else if (cfg_valid && cfg_ready && cfg_index == trp_pkg::CFG_OFFSET)
        begin
            offset_reg <= cfg_data;
        end
    end

    trp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    trp_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (in_valid),
        .position (position),
        .offset   (offset_reg),
        .cfg      (cfg),
        .m_v      (m_v),
        .m        (m)
    );

    trp_region u_region (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .m_v    (m_v),
        .m      (m),
        .cfg    (cfg),
        .prod_v (prod_v),
        .prod   (prod),
        .region (prod_rg)
    );

    trp_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_v     (prod_v),
        .prod       (prod),
        .region_in  (prod_rg),
        .cfg        (cfg),
        .q_v        (q_v),
        .quotient   (quotient),
        .region_out (q_rg)
    );

    // The quotient is a magnitude; a negative height turns it around.
    always_comb
    begin
        unique case (q_rg)
            trp_pkg::REG_TOP:  level_next = cfg.height;
            trp_pkg::REG_RAMP: level_next = cfg.h_neg ? 32'(-$signed(quotient))
                                                      : $signed(quotient);
            trp_pkg::REG_ZERO: level_next = 32'sd0;
            default:           level_next = 32'sd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

`ifndef SYNTHESIS
    a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && q_v && q_rg == trp_pkg::REG_ZERO) |=> (level == 32'sd0))
        else $error("sample between the ramps gave a nonzero level");

    a_top_height: assert property (@(posedge clk) disable iff (!rst_n)
        (en && q_v && q_rg == trp_pkg::REG_TOP) |=> (level == $past(cfg.height)))
        else $error("sample on the flat top did not give the height");
`endif

endmodule
